/* src/lras_pkg.sv */
// ----------------------------------------------------------------------------
// lras_pkg
// shared types and codes for the range add / range sum block
// ----------------------------------------------------------------------------
package lras_pkg;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_QRY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_ADD_MUL,
        ST_ADD_SCL,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_RD,
        ST_Q_ACC,
        ST_Q_MLO,
        ST_Q_MHI,
        ST_Q_FIN,
        ST_OUT
    } t_state;

endpackage

/* src/lazy_range_add_sum_tree_top.sv */
// ----------------------------------------------------------------------------
// lazy_range_add_sum_tree_top
// range add / range sum over LEAVES signed 64-bit elements, zero after reset.
// after reset the block is busy while it clears its memory.
// the elements are held as two binary indexed trees packed in one 128-bit
// single-port memory with a registered read; every tree node visit is a
// read followed by a write back (add) or by an accumulate (query). an add
// walks up from both range ends; a query walks down from both ends and
// scales each prefix with two 32-bit multiplies. an empty add never raises
// busy. a query result appears on o_range_sum for one cycle with o_valid
// and must be taken then.
// ----------------------------------------------------------------------------
module lazy_range_add_sum_tree_top #(
    parameter int LEAVES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [9:0]         i_range_low,
    input  logic [9:0]         i_range_high,
    input  logic signed [31:0] i_add_value,
    output logic               o_valid,
    output logic signed [63:0] o_range_sum
);
    import lras_pkg::*;

    localparam int AW = $clog2(LEAVES);
    localparam int PW = ($clog2(LEAVES) + 2 > 12) ? $clog2(LEAVES) + 2 : 12;
    localparam int MW = 34 + PW;
    localparam logic [PW-1:0] N_P = PW'(LEAVES);

    t_state r_state, n_state;

    logic [127:0] mem [LEAVES];
    logic [127:0] r_rdata;

    logic [PW-1:0] r_p, r_x, r_a, r_bc;
    logic          r_pt, r_pass;
    logic signed [31:0] r_v;
    logic [63:0] r_d1, r_d2, r_s1, r_s2, r_lo, r_acc;
    logic signed [MW-1:0] r_mp;

    logic [PW-1:0] pm1, lsb, b_ext, bc, a_ext;
    logic          empty, accept;
    logic signed [32:0] m_a;
    logic signed [PW:0] m_b;
    logic signed [MW-1:0] prod;
    logic [63:0] mp64, term;

    logic rd_en, wr_en;
    logic [AW-1:0] addr;
    logic [127:0] w_data;

    assign accept = start && !busy;
    assign a_ext  = PW'(i_range_low);
    assign b_ext  = PW'(i_range_high);
    assign bc     = (b_ext >= N_P) ? N_P - PW'(1) : b_ext;
    assign empty  = a_ext > bc;
    assign pm1    = r_p - PW'(1);
    assign lsb    = r_p & (~r_p + PW'(1));

    assign m_a  = (r_state == ST_ADD_MUL) ? {r_v[31], r_v} :
                  (r_state == ST_Q_MHI)   ? {1'b0, r_s1[63:32]} : {1'b0, r_s1[31:0]};
    assign m_b  = {1'b0, r_x};
    assign prod = MW'(m_a) * MW'(m_b);
    assign mp64 = {{(64-MW){r_mp[MW-1]}}, r_mp};
    assign term = r_lo + {r_mp[31:0], 32'h0} - r_s2;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:     if (r_p == N_P - PW'(1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    if (empty) n_state = (i_operation == OP_QRY) ? ST_OUT : ST_IDLE;
                    else       n_state = (i_operation == OP_QRY) ? ST_Q_RD : ST_ADD_MUL;
                end
            end
            ST_ADD_MUL: n_state = ST_ADD_SCL;
            ST_ADD_SCL: n_state = ST_ADD_RD;
            ST_ADD_RD: begin
                if (r_p <= N_P)  n_state = ST_ADD_WR;
                else if (!r_pt)  n_state = ST_ADD_MUL;
                else             n_state = ST_IDLE;
            end
            ST_ADD_WR:  n_state = ST_ADD_RD;
            ST_Q_RD:    n_state = (r_p != '0) ? ST_Q_ACC : ST_Q_MLO;
            ST_Q_ACC:   n_state = ST_Q_RD;
            ST_Q_MLO:   n_state = ST_Q_MHI;
            ST_Q_MHI:   n_state = ST_Q_FIN;
            ST_Q_FIN:   n_state = r_pass ? ST_OUT : ST_Q_RD;
            ST_OUT:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        busy   = 1'b1;
        o_valid = 1'b0;
        rd_en  = 1'b0;
        wr_en  = 1'b0;
        addr   = pm1[AW-1:0];
        w_data = {r_rdata[127:64] + r_d1, r_rdata[63:0] + r_d2};
        unique case (r_state)
            ST_CLR: begin
                wr_en  = 1'b1;
                addr   = r_p[AW-1:0];
                w_data = '0;
            end
            ST_IDLE:   busy  = 1'b0;
            ST_ADD_RD: rd_en = (r_p <= N_P);
            ST_ADD_WR: wr_en = 1'b1;
            ST_Q_RD:   rd_en = (r_p != '0);
            ST_OUT:    o_valid = 1'b1;
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign o_range_sum = r_acc;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[addr] <= w_data;
        if (rd_en) r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_p     <= '0;
            r_pt    <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_CLR: r_p <= r_p + PW'(1);
                ST_IDLE: begin
                    r_pt   <= 1'b0;
                    r_pass <= 1'b0;
                    if (accept) begin
                        r_p <= (i_operation == OP_ADD) ? a_ext + PW'(1) : bc + PW'(1);
                    end
                end
                ST_ADD_RD: begin
                    if (!(r_p <= N_P) && !r_pt) begin
                        r_pt <= 1'b1;
                        r_p  <= r_bc + PW'(2);
                    end
                end
                ST_ADD_WR: r_p <= r_p + lsb;
                ST_Q_ACC:  r_p <= r_p - lsb;
                ST_Q_FIN: begin
                    r_pass <= 1'b1;
                    r_p    <= r_a;
                end
                default: r_p <= r_p;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mp <= prod;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_a   <= a_ext;
                    r_bc  <= bc;
                    r_v   <= i_add_value;
                    r_acc <= '0;
                    r_s1  <= '0;
                    r_s2  <= '0;
                    r_x   <= (i_operation == OP_ADD) ? a_ext : bc + PW'(1);
                end
            end
            ST_ADD_SCL: begin
                r_d1 <= r_pt ? -{{32{r_v[31]}}, r_v} : {{32{r_v[31]}}, r_v};
                r_d2 <= r_pt ? -mp64 : mp64;
            end
            ST_ADD_RD: begin
                if (!(r_p <= N_P) && !r_pt) r_x <= r_bc + PW'(1);
            end
            ST_Q_ACC: begin
                r_s1 <= r_s1 + r_rdata[127:64];
                r_s2 <= r_s2 + r_rdata[63:0];
            end
            ST_Q_MHI: r_lo <= mp64;
            ST_Q_FIN: begin
                r_acc <= r_pass ? r_acc - term : r_acc + term;
                r_x   <= r_a;
                r_s1  <= '0;
                r_s2  <= '0;
            end
            default: begin
            end
        endcase
    end

endmodule

/* src/lras_chk.sv */
// ----------------------------------------------------------------------------
// lras_chk
// port-level checks for the range add / range sum block
// ----------------------------------------------------------------------------
module lras_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [63:0] o_range_sum
);
    // result word lasts one cycle
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result shown while idle");

    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("not idle after result");

    // memory clear holds off commands
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("not busy after reset");

    a_known_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_range_sum))
        else $error("unknown result word");

endmodule

bind lazy_range_add_sum_tree_top lras_chk u_lras_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_range_sum(o_range_sum)
);

/* dv/lazy_range_add_sum_tree_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_range_add_sum_tree_top_tb
// drives random and corner range adds and range sums into the tree and
// compares every returned sum against a flat-array model of the elements
// ----------------------------------------------------------------------------
module lazy_range_add_sum_tree_top_tb;
    import lras_pkg::*;

    localparam int LEAVES = 1024;

    class range_sum_board;
        logic [63:0] elem_val [LEAVES];
        logic [63:0] sum_queue [$];
        int          mismatches;

        function new();
            foreach (elem_val[k]) elem_val[k] = '0;
            mismatches = 0;
        endfunction

        function void note_word(logic op, logic [9:0] lo, logic [9:0] hi,
                                logic signed [31:0] amount);
            logic [63:0] acc;
            acc = '0;
            for (int k = lo; k <= hi; k++) begin
                if (op == OP_ADD) begin
                    elem_val[k] = elem_val[k] + 64'(amount);
                end else begin
                    acc = acc + elem_val[k];
                end
            end
            if (op == OP_QRY) begin
                sum_queue = {sum_queue, acc};
            end
        endfunction

        function void check_sum(logic [63:0] got);
            logic [63:0] want;
            if (sum_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected sum word: got %h", got);
            end else begin
                want = sum_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("range_sum mismatch: expected %h actual %h", want, got);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [9:0]         i_range_low;
    logic [9:0]         i_range_high;
    logic signed [31:0] i_add_value;
    logic               o_valid;
    logic signed [63:0] o_range_sum;

    range_sum_board board;

    lazy_range_add_sum_tree_top #(.LEAVES(LEAVES)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_add_value  (i_add_value),
        .o_valid      (o_valid),
        .o_range_sum  (o_range_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_sum(o_range_sum);
    end

    task automatic send_word(logic op, logic [9:0] lo, logic [9:0] hi,
                             logic signed [31:0] amount, bit allow_gap);
        start        <= 1'b1;
        i_operation  <= op;
        i_range_low  <= lo;
        i_range_high <= hi;
        i_add_value  <= amount;
        do @(posedge i_clk); while (busy);
        board.note_word(op, lo, hi, amount);
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(bit allow_gap);
        logic [9:0]  lo;
        logic [9:0]  hi;
        logic [31:0] amount;
        int          span;
        lo   = 10'($urandom_range(0, LEAVES - 1));
        span = int'($urandom_range(0, 40));
        case ($urandom_range(0, 5))
            0:       hi = 10'($urandom_range(0, LEAVES - 1));
            1: begin
                lo = 10'd0;
                hi = 10'(LEAVES - 1);
            end
            2:       hi = (lo > 10'd0) ? lo - 10'd1 : 10'd0;
            default: hi = (int'(lo) + span > LEAVES - 1) ?
                          10'(LEAVES - 1) : 10'(int'(lo) + span);
        endcase
        case ($urandom_range(0, 7))
            0:       amount = 32'h7fff_ffff;
            1:       amount = 32'h8000_0000;
            default: amount = $urandom;
        endcase
        send_word($urandom_range(0, 1) ? OP_QRY : OP_ADD, lo, hi, amount, allow_gap);
    endtask

    initial begin
        int wait_cycles;
        board        = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_operation  = OP_ADD;
        i_range_low  = '0;
        i_range_high = '0;
        i_add_value  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: full range, ends, empty ranges, extreme amounts
        send_word(OP_QRY, 10'd0, 10'd1023, 32'sd0, 1'b0);
        send_word(OP_ADD, 10'd0, 10'd1023, 32'sh7fff_ffff, 1'b0);
        send_word(OP_QRY, 10'd0, 10'd1023, 32'sd0, 1'b1);
        send_word(OP_ADD, 10'd1023, 10'd1023, 32'sh8000_0000, 1'b0);
        send_word(OP_QRY, 10'd1023, 10'd1023, 32'sd0, 1'b0);
        send_word(OP_QRY, 10'd0, 10'd0, 32'sd0, 1'b1);
        send_word(OP_ADD, 10'd5, 10'd4, 32'sh1234_5678, 1'b0);
        send_word(OP_QRY, 10'd1023, 10'd0, 32'shffff_ffff, 1'b0);
        send_word(OP_ADD, 10'd0, 10'd0, 32'shffff_ffff, 1'b1);
        send_word(OP_ADD, 10'd1, 10'd1022, 32'sh8000_0000, 1'b0);
        send_word(OP_QRY, 10'd0, 10'd1023, 32'sd0, 1'b0);
        send_word(OP_QRY, 10'd511, 10'd512, 32'sd0, 1'b0);
        send_word(OP_ADD, 10'd300, 10'd700, 32'sh0000_0001, 1'b0);
        send_word(OP_QRY, 10'd299, 10'd701, 32'sd0, 1'b1);
        send_word(OP_QRY, 10'd0, 10'd511, 32'sd0, 1'b0);
        send_word(OP_QRY, 10'd512, 10'd1023, 32'sd0, 1'b0);

        for (int n = 0; n < 1450; n++) send_random(1'b1);
        for (int n = 0; n < 200; n++) send_random(1'b0);
        start <= 1'b0;

        wait_cycles = 0;
        while (board.sum_queue.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (80) @(posedge i_clk);

        if (board.mismatches == 0 && board.sum_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

/* files.f */
src/lras_pkg.sv
src/lazy_range_add_sum_tree_top.sv
src/lras_chk.sv
dv/lazy_range_add_sum_tree_top_tb.sv
